[sv/rrtd_pkg.sv]
// Shared types and constants of the RLE RGB texel decoder.
package rrtd_pkg;

    localparam int TEXEL_W     = 24;
    localparam int COUNT_W     = 3;
    localparam int TAG_COUNT_W = 8;
    localparam int OUT_DATA_W  = 128;
    localparam int OUT_USER_W  = 2;

    // Result group size, clamped to the four texel slots of a result.
    localparam logic [COUNT_W-1:0] GROUP_SIZE = 3'd4;

    localparam int           TAG_RUN_BIT = 7;
    localparam logic [7:0]   COUNT_MASK  = 8'h7F;
    localparam logic [1:0]   LAST_BYTE   = 2'd2;

    // Byte address of the texel_total register.
    localparam logic [1:0]   ADDR_TEXEL_TOTAL = 2'd0;

    typedef enum logic [2:0] {
        ST_TAG,
        ST_RUN,
        ST_LIT,
        ST_SKIP,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load_tag;
        logic shift_byte;
        logic run_start;
        logic run_emit;
        logic lit_emit;
        logic skip_texel;
    } dp_cmd_t;

    typedef struct packed {
        logic tag_is_run;
        logic texel_done;
        logic left_last;
        logic lit_end;
        logic group_last;
        logic out_free;
    } dp_status_t;

endpackage

[sv/rrtd_ctrl.sv]
// Decode sequencer: tracks tag, run, literal and skip phases and run expansion.
module rrtd_ctrl
    import rrtd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        accept;

    assign s_tready = (state_reg != ST_EMIT) && status.out_free;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_TAG;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_TAG: begin
                if (accept) begin
                    state_next = status.tag_is_run ? ST_RUN : ST_LIT;
                end
            end
            ST_RUN: begin
                if (accept && status.texel_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_LIT: begin
                if (accept && status.texel_done) begin
                    priority if (status.left_last) begin
                        state_next = ST_TAG;
                    end else if (status.lit_end) begin
                        state_next = ST_SKIP;
                    end else begin
                        state_next = ST_LIT;
                    end
                end
            end
            ST_SKIP: begin
                if (accept && status.texel_done && status.left_last) begin
                    state_next = ST_TAG;
                end
            end
            ST_EMIT: begin
                if (status.out_free && status.group_last) begin
                    state_next = ST_TAG;
                end
            end
            default: begin
                state_next = ST_TAG;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_TAG: begin
                cmd.load_tag = accept;
            end
            ST_RUN: begin
                cmd.shift_byte = accept && !status.texel_done;
                cmd.run_start  = accept && status.texel_done;
            end
            ST_LIT: begin
                cmd.shift_byte = accept && !status.texel_done;
                cmd.lit_emit   = accept && status.texel_done;
            end
            ST_SKIP: begin
                cmd.shift_byte = accept && !status.texel_done;
                cmd.skip_texel = accept && status.texel_done;
            end
            ST_EMIT: begin
                cmd.run_emit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    a_no_input_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !s_tready)
        else $error("input accepted while a run is being expanded");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_tag, cmd.shift_byte, cmd.run_start, cmd.run_emit,
                  cmd.lit_emit, cmd.skip_texel}))
        else $error("more than one datapath command in a cycle");

    a_run_goes_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.run_start |=> (state_reg == ST_EMIT))
        else $error("run color complete but no expansion started");

endmodule

[sv/rrtd_dpath.sv]
// Datapath: byte assembly, tag counters, texel position and the result register.
module rrtd_dpath
    import rrtd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             s_tdata,
    input  logic [TEXEL_W-1:0]     texel_total,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tlast,
    output logic [OUT_USER_W-1:0]  m_tuser
);

    logic [15:0]            partial_reg, partial_next;
    logic [1:0]             byte_cnt_reg, byte_cnt_next;
    logic [TAG_COUNT_W-1:0] left_reg, left_next;
    logic [TAG_COUNT_W-1:0] run_left_reg, run_left_next;
    logic [TEXEL_W-1:0]     written_reg, written_next;
    logic                   cut_reg, cut_next;
    logic [TEXEL_W-1:0]     color_reg, color_next;

    logic                   m_valid_reg, m_valid_next;
    logic [TEXEL_W-1:0]     tex_reg [4];
    logic [TEXEL_W-1:0]     tex_next [4];
    logic [COUNT_W-1:0]     cnt_reg, cnt_next;
    logic [TEXEL_W-1:0]     first_reg, first_next;
    logic                   last_reg, last_next;
    logic                   end_reg, end_next;
    logic                   ovr_reg, ovr_next;

    logic [TEXEL_W-1:0]     total_eff;
    logic [TEXEL_W-1:0]     room;
    logic [TAG_COUNT_W-1:0] tag_count;
    logic [TEXEL_W-1:0]     color;
    logic [TEXEL_W:0]       lit_sum;
    logic                   lit_end;
    logic [COUNT_W-1:0]     grp_cnt;
    logic                   grp_last;
    logic [TEXEL_W-1:0]     grp_sum;
    logic                   grp_end;
    logic                   out_free;
    logic                   emit;

    assign total_eff = (texel_total == '0) ? 24'd1 : texel_total;
    // Texels still free in the table; one when the total was lowered mid-table.
    assign room      = (total_eff > written_reg) ? (total_eff - written_reg) : 24'd1;
    assign tag_count = (s_tdata & COUNT_MASK) + 8'd1;
    assign color     = {partial_reg, s_tdata};
    assign lit_sum   = {1'b0, written_reg} + 25'd1;
    assign lit_end   = lit_sum >= {1'b0, total_eff};
    assign grp_last  = run_left_reg <= {5'b0, GROUP_SIZE};
    assign grp_cnt   = grp_last ? run_left_reg[COUNT_W-1:0] : GROUP_SIZE;
    assign grp_sum   = written_reg + {21'b0, grp_cnt};
    assign grp_end   = grp_last && (grp_sum >= total_eff);
    assign out_free  = !m_valid_reg || m_tready;
    assign emit      = cmd.run_emit || cmd.lit_emit;

    always_comb begin
        status.tag_is_run = s_tdata[TAG_RUN_BIT];
        status.texel_done = byte_cnt_reg == LAST_BYTE;
        status.left_last  = left_reg <= 8'd1;
        status.lit_end    = lit_end;
        status.group_last = grp_last;
        status.out_free   = out_free;
    end

    always_comb begin
        partial_next  = partial_reg;
        byte_cnt_next = byte_cnt_reg;
        left_next     = left_reg;
        run_left_next = run_left_reg;
        written_next  = written_reg;
        cut_next      = cut_reg;
        color_next    = color_reg;

        if (cmd.load_tag) begin
            left_next     = tag_count;
            byte_cnt_next = '0;
            partial_next  = '0;
            cut_next      = s_tdata[TAG_RUN_BIT] ? 1'b0 : ({16'b0, tag_count} > room);
        end
        if (cmd.shift_byte) begin
            partial_next  = {partial_reg[7:0], s_tdata};
            byte_cnt_next = byte_cnt_reg + 2'd1;
        end
        if (cmd.run_start || cmd.lit_emit || cmd.skip_texel) begin
            partial_next  = '0;
            byte_cnt_next = '0;
        end
        if (cmd.run_start) begin
            color_next = color;
            left_next  = '0;
            // A cut run keeps only the texels left in the table, which fit in eight bits.
            if ({16'b0, left_reg} > room) begin
                cut_next      = 1'b1;
                run_left_next = room[TAG_COUNT_W-1:0];
            end else begin
                cut_next      = 1'b0;
                run_left_next = left_reg;
            end
        end
        if (cmd.run_emit) begin
            run_left_next = run_left_reg - {5'b0, grp_cnt};
            written_next  = grp_end ? '0 : grp_sum;
            if (grp_last) begin
                cut_next = 1'b0;
            end
        end
        if (cmd.lit_emit) begin
            written_next = lit_end ? '0 : lit_sum[TEXEL_W-1:0];
        end
        if (cmd.lit_emit || cmd.skip_texel) begin
            left_next = left_reg - 8'd1;
            if (left_reg <= 8'd1) begin
                left_next = '0;
                cut_next  = 1'b0;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        cnt_next     = cnt_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        end_next     = end_reg;
        ovr_next     = ovr_reg;
        for (int i = 0; i < 4; i++) begin
            tex_next[i] = tex_reg[i];
        end

        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.run_emit) begin
            m_valid_next = 1'b1;
            cnt_next     = grp_cnt;
            first_next   = written_reg;
            last_next    = grp_last;
            end_next     = grp_end;
            ovr_next     = cut_reg;
            for (int i = 0; i < 4; i++) begin
                tex_next[i] = (i < int'(grp_cnt)) ? color_reg : '0;
            end
        end else if (cmd.lit_emit) begin
            m_valid_next = 1'b1;
            cnt_next     = 3'd1;
            first_next   = written_reg;
            last_next    = 1'b1;
            end_next     = lit_end;
            ovr_next     = cut_reg;
            tex_next[0]  = color;
            for (int i = 1; i < 4; i++) begin
                tex_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg  <= '0;
            byte_cnt_reg <= '0;
            left_reg     <= '0;
            run_left_reg <= '0;
            written_reg  <= '0;
            cut_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            partial_reg  <= partial_next;
            byte_cnt_reg <= byte_cnt_next;
            left_reg     <= left_next;
            run_left_reg <= run_left_next;
            written_reg  <= written_next;
            cut_reg      <= cut_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        color_reg <= color_next;
        cnt_reg   <= cnt_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        end_reg   <= end_next;
        ovr_reg   <= ovr_next;
        for (int i = 0; i < 4; i++) begin
            tex_reg[i] <= tex_next[i];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, first_reg, cnt_reg, tex_reg[3], tex_reg[2], tex_reg[1], tex_reg[0]};
    assign m_tlast  = last_reg;
    assign m_tuser  = {ovr_reg, end_reg};

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result loaded over one not yet transferred");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (cnt_reg != 3'd0 && cnt_reg <= GROUP_SIZE))
        else $error("result carries an impossible texel count");

    a_table_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.run_emit && grp_end) |=> (written_reg == '0 && m_tuser[0]))
        else $error("table end did not restart the texel index");

    a_run_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.run_emit |-> (run_left_reg != '0))
        else $error("run expansion with no texels left");

endmodule

[sv/rle_rgb_texel_decoder.sv]
// RLE decoder for 24-bit RGB texel tables, with its register port.
//
// Compressed bytes enter one per transfer on the s_ channel (s_tdata[7:0]).
// A tag byte with bit 7 set starts a run: three color bytes follow and the
// texel repeats count times. Otherwise count literal three-byte texels follow.
// Each result on the m_ channel carries up to four texels, their count and
// the table index of the first; m_tlast marks the last result of an input
// byte, m_tuser[0] the end of the table and m_tuser[1] a cut run or span.
// Register texel_total at byte address 0 sets the texels per table.
//
// Tag bytes and color bytes are taken at one per cycle. A literal texel's
// result is valid in the cycle after its third byte is transferred. A run of
// n texels yields ceil(n/4) results, up to 32, after its third color
// byte, loaded into the result register in turn; no byte is taken then.
// When the receiver stalls, the result register holds its transfer and no
// byte is taken while a result waits with m_tready low. Reset empties the
// result register, sets the total to one and restarts decoding at a tag byte
// with texel index zero.
module rle_rgb_texel_decoder
    import rrtd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,  // [7:0] compressed_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [23:0] texel_a, [47:24] texel_b, [71:48] texel_c, [95:72] texel_d,
    // [98:96] texel_valid_count, [122:99] first_texel_index, rest zero
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tlast,  // last_of_run
    output logic [OUT_USER_W-1:0]  m_tuser,  // [0] table_end, [1] overrun
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [1:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [TEXEL_W-1:0] total_reg, total_next;
    logic               cfg_write;
    dp_cmd_t            cmd;
    dp_status_t         status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_TEXEL_TOTAL);
    assign total_next = cfg_write ? pwdata[TEXEL_W-1:0] : total_reg;
    assign prdata    = (paddr == ADDR_TEXEL_TOTAL) ? {8'b0, total_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= 24'd1;
        end else begin
            total_reg <= total_next;
        end
    end

    rrtd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rrtd_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .texel_total (total_reg),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

[sim/testbench.sv]
// Self-checking testbench for the RLE RGB texel decoder.
module testbench;
    import rrtd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SETTLE_CYCLES   = 40;
    localparam int          CYCLE_LIMIT     = 1_000_000;
    localparam int          REPORT_LIMIT    = 10;
    localparam logic [23:0] MASK24          = 24'hFFFFFF;

    typedef struct packed {
        logic [23:0] tx_a;
        logic [23:0] tx_b;
        logic [23:0] tx_c;
        logic [23:0] tx_d;
        logic [2:0]  cnt;
        logic [23:0] first;
        logic        last;
        logic        tbl_end;
        logic        ovr;
    } texel_group_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [1:0]            paddr    = 2'd0;
    logic [31:0]           pwdata   = 32'h0;
    logic [31:0]           prdata;
    logic                  pready;

    rle_rgb_texel_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Decoder state as the stream implies it, plus the programmed total.
    ctrl_state_t  dec_phase      = ST_TAG;
    int unsigned  texels_pending = 0;
    int unsigned  color_bytes    = 0;
    logic [15:0]  color_hi       = 16'h0;
    logic [23:0]  texels_done    = 24'h0;
    logic         span_cut       = 1'b0;
    logic [23:0]  table_total    = 24'd1;

    texel_group_t texel_groups_due[$];

    int errors         = 0;
    int bytes_sent     = 0;
    int groups_checked = 0;
    int tables_ended   = 0;
    int cycles         = 0;

    bit src_idle_en       = 1'b0;
    bit sink_idle_en      = 1'b0;
    int hold_sink_cycles  = 0;

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function automatic int unsigned effective_total();
        return (table_total == 24'd0) ? 1 : int'(table_total);
    endfunction

    function automatic int unsigned texels_room();
        int unsigned t;
        t = effective_total();
        return (t > texels_done) ? t - texels_done : 1;
    endfunction

    function automatic void queue_group(input logic [23:0] color, input int unsigned cnt,
                                        input logic [23:0] first, input logic last,
                                        input logic fin, input logic ovr);
        texel_group_t g;
        g.tx_a    = color;
        g.tx_b    = (cnt >= 2) ? color : 24'h0;
        g.tx_c    = (cnt >= 3) ? color : 24'h0;
        g.tx_d    = (cnt >= 4) ? color : 24'h0;
        g.cnt     = cnt[2:0];
        g.first   = first;
        g.last    = last;
        g.tbl_end = fin;
        g.ovr     = ovr;
        texel_groups_due.push_back(g);
    endfunction

    // Advances the predicted decoder by one compressed byte and queues the
    // groups of texels that the byte releases.
    function automatic void decode_byte(input logic [7:0] b);
        logic [23:0] color;
        logic [23:0] first;
        int unsigned n;
        int unsigned room;
        int unsigned idx;
        int unsigned cnt;
        logic        fin;
        logic        last;
        if (dec_phase == ST_TAG) begin
            texels_pending = (b & COUNT_MASK) + 1;
            color_bytes    = 0;
            color_hi       = 16'h0;
            if (b[TAG_RUN_BIT]) begin
                dec_phase = ST_RUN;
                span_cut  = 1'b0;
            end else begin
                dec_phase = ST_LIT;
                span_cut  = texels_pending > texels_room();
            end
            return;
        end
        if (color_bytes < 2) begin
            color_hi = {color_hi[7:0], b};
            color_bytes++;
            return;
        end
        color       = {color_hi, b};
        color_bytes = 0;
        color_hi    = 16'h0;
        case (dec_phase)
            ST_RUN: begin
                n        = texels_pending;
                room     = texels_room();
                span_cut = n > room;
                if (n > room)
                    n = room;
                idx = 0;
                while (idx < n) begin
                    cnt = (n - idx > GROUP_SIZE) ? GROUP_SIZE : n - idx;
                    first = texels_done;
                    idx += cnt;
                    texels_done = 24'((texels_done + cnt) & MASK24);
                    last = (idx == n);
                    fin  = last && (texels_done >= effective_total());
                    if (fin)
                        texels_done = 24'h0;
                    queue_group(color, cnt, first, last, fin, span_cut);
                end
                dec_phase      = ST_TAG;
                texels_pending = 0;
                span_cut       = 1'b0;
            end
            ST_LIT: begin
                fin = (texels_done + 1 >= effective_total());
                queue_group(color, 1, texels_done, 1'b1, fin, span_cut);
                texels_done = fin ? 24'h0 : 24'((texels_done + 1) & MASK24);
                if (texels_pending > 0)
                    texels_pending--;
                if (texels_pending == 0) begin
                    dec_phase = ST_TAG;
                    span_cut  = 1'b0;
                end else if (fin) begin
                    dec_phase = ST_SKIP;
                end
            end
            default: begin
                // Tail of a span that overshot the table is dropped.
                if (texels_pending > 0)
                    texels_pending--;
                if (texels_pending == 0) begin
                    dec_phase = ST_TAG;
                    span_cut  = 1'b0;
                end
            end
        endcase
    endfunction

    // All driving tasks are entered right after a rising edge.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        decode_byte(b);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (texel_groups_due.size() != 0)
            @(posedge aclk);
        // Any result beyond the predicted ones would show up during this wait.
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_texel_total(input logic [23:0] value);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TEXEL_TOTAL;
        pwdata  <= {8'($urandom_range(0, 255)), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        table_total = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        if (rd[23:0] !== value)
            note_error($sformatf("texel_total read back %h, wrote %h", rd[23:0], value));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_run(input int unsigned count, input logic [23:0] color);
        push_byte(8'h80 | 8'(count - 1));
        push_byte(color[23:16]);
        push_byte(color[15:8]);
        push_byte(color[7:0]);
    endtask

    task automatic send_span(input int unsigned count);
        push_byte(8'(count - 1) & COUNT_MASK);
        repeat (3 * count) push_byte(8'($urandom));
    endtask

    // Reset total of one: a two-texel span ends the table on its first
    // texel, is flagged as cut and its second texel is dropped.
    task automatic test_reset_total();
        logic [31:0] rd;
        psel  <= 1'b1;
        paddr <= ADDR_TEXEL_TOTAL;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        if (rd[23:0] !== 24'd1)
            note_error($sformatf("texel_total after reset is %h", rd[23:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        push_byte(8'h01);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'hFF);
        wait_for_results();
    endtask

    task automatic test_run_extremes();
        set_texel_total(24'hFFFFFF);
        send_run(128, 24'hFFFFFF);
        send_run(1, 24'h000000);
        wait_for_results();
    endtask

    // Lowering the total below the texels already written ends the table
    // on the next texel; a zero total behaves as one.
    task automatic test_total_change();
        set_texel_total(24'd5);
        send_run(3, 24'hA5C3E1);
        wait_for_results();
        set_texel_total(24'd0);
        send_run(2, 24'h5A3C1E);
        wait_for_results();
    endtask

    // The receiver holds off while bytes keep coming, so the decoder backs
    // up; then the sender waits for every pending group.
    task automatic test_backpressure();
        set_texel_total(24'd1000);
        hold_sink_cycles = 300;
        send_run(128, 24'h123456);
        send_run(50, 24'h654321);
        send_span(3);
        send_run(7, 24'h0F0F0F);
        wait_for_results();
    endtask

    task automatic send_random_sequence();
        int unsigned kind;
        int unsigned pick;
        int unsigned count;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 19);
        if (kind < 45) begin
            count = (pick == 0) ? 128 : (pick < 4) ? $urandom_range(9, 127)
                                                   : $urandom_range(1, 8);
            send_run(count, 24'($urandom));
        end else if (kind < 90) begin
            count = (pick < 3) ? $urandom_range(7, 16) : $urandom_range(1, 6);
            send_span(count);
        end else begin
            // Stray byte: breaks the framing of whatever follows.
            push_byte(8'($urandom));
        end
    endtask

    task automatic test_random_tables();
        logic [23:0] totals [5];
        int          start;
        totals[0] = 24'($urandom_range(2, 12));
        totals[1] = 24'd1;
        totals[2] = 24'hFFFFFF;
        totals[3] = 24'($urandom_range(13, 400));
        totals[4] = 24'd0;
        for (int p = 0; p < 5; p++) begin
            set_texel_total(totals[p]);
            src_idle_en  = (p != 2) && (p != 4);
            sink_idle_en = (p != 4);
            start = bytes_sent;
            while (bytes_sent - start < 30)
                send_random_sequence();
            wait_for_results();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        test_reset_total();
        test_run_extremes();
        test_total_change();
        test_backpressure();
        test_random_tables();
        $display("Sent %0d compressed bytes: runs up to 128, literal spans, cut spans, stray",
                 bytes_sent);
        $display("bytes and totals 0, 1 and 2^24-1; %0d results checked, %0d tables ended.",
                 groups_checked, tables_ended);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Receiver ready: random stall bursts and one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_sink_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_sink_cycles) @(posedge aclk);
                hold_sink_cycles = 0;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void compare_field(input string name, input logic [23:0] want,
                                          input logic [23:0] seen);
        if (seen !== want)
            note_error($sformatf("result %0d %s: expected %h, got %h",
                                 groups_checked, name, want, seen));
    endfunction

    always @(posedge aclk) begin : result_check
        texel_group_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (texel_groups_due.size() == 0) begin
                note_error($sformatf("unexpected result transfer, tdata %h", m_tdata));
            end else begin
                want = texel_groups_due.pop_front();
                compare_field("texel_a", want.tx_a, m_tdata[23:0]);
                compare_field("texel_b", want.tx_b, m_tdata[47:24]);
                compare_field("texel_c", want.tx_c, m_tdata[71:48]);
                compare_field("texel_d", want.tx_d, m_tdata[95:72]);
                compare_field("texel_valid_count", 24'(want.cnt), 24'(m_tdata[98:96]));
                compare_field("first_texel_index", want.first, m_tdata[122:99]);
                compare_field("tdata padding", 24'h0, 24'(m_tdata[127:123]));
                compare_field("last_of_run", 24'(want.last), 24'(m_tlast));
                compare_field("table_end", 24'(want.tbl_end), 24'(m_tuser[0]));
                compare_field("overrun", 24'(want.ovr), 24'(m_tuser[1]));
                groups_checked++;
                if (want.tbl_end)
                    tables_ended++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycles, texel_groups_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
